// ===== design/tensor_block_address_gen_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TENSOR_BLOCK_ADDRESS_GEN_TOP_ASSERT_SVH
`define TENSOR_BLOCK_ADDRESS_GEN_TOP_ASSERT_SVH

// Implication checked only while out of reset.
`define TBAG_ASSERT_RUN(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tbag checker: property failed");

// Next-cycle implication checked at every edge, reset included.
`define TBAG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tbag checker: property failed");

`endif

// ===== design/tbag_pkg.sv =====
`default_nettype none
package tbag_pkg;

    localparam int DIMS       = 4;
    localparam int HW_DIMS    = 4;
    localparam int EXTENT_MAX = 256;
    localparam int EXT_W      = 9;
    localparam int OFS_W      = 32;
    localparam int START_W    = 8;
    localparam int REM_W      = 8;
    localparam int TS_W       = 25;
    localparam int PROD_W     = 34;
    localparam int IDX_W      = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STAGES = DIMS * OFS_W;

    localparam logic [CFG_IDX_W-1:0] REG_TENSOR_EXTENT_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_EXTENT_0  = 3'd4;

    typedef struct packed {
        logic                             valid;
        logic [OFS_W-1:0]                 num;
        logic [REM_W-1:0]                 rem;
        logic [HW_DIMS-1:0][REM_W-1:0]    coord;
        logic [HW_DIMS-1:0][START_W-1:0]  start;
    } t_stage;

    function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] raw);
        logic [EXT_W-1:0] res;
        if (raw == '0) begin
            res = EXT_W'(1);
        end else if (raw > EXT_W'(EXTENT_MAX)) begin
            res = EXT_W'(EXTENT_MAX);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/tensor_block_address_gen_top.sv =====
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_block_offset, i_start_0..3
// output    o_valid   i_stall   o_flat_index
// config    i_cfg_we  (none)    i_cfg_idx, i_cfg_data
//
// One transaction enters per cycle while o_stall is low.
// The pipeline is made of the bit-per-stage dividers, 32 stages per dimension,
// followed by one multiply stage and one sum stage.
// A stall on a valid output freezes the whole pipeline in place.
// Reset clears all valid bits and sets every extent register to one.
`default_nettype none
module tensor_block_address_gen_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [tbag_pkg::OFS_W-1:0]           i_block_offset,
    input  wire logic [tbag_pkg::START_W-1:0]         i_start_0,
    input  wire logic [tbag_pkg::START_W-1:0]         i_start_1,
    input  wire logic [tbag_pkg::START_W-1:0]         i_start_2,
    input  wire logic [tbag_pkg::START_W-1:0]         i_start_3,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [tbag_pkg::IDX_W-1:0]                o_flat_index,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tbag_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [tbag_pkg::EXT_W-1:0]           i_cfg_data
);
    import tbag_pkg::*;

    logic [HW_DIMS-1:0][EXT_W-1:0]  r_text;
    logic [HW_DIMS-1:0][EXT_W-1:0]  r_bext;
    logic [HW_DIMS-1:0][EXT_W-1:0]  w_bdiv;
    logic [HW_DIMS-1:0][TS_W-1:0]   r_ts;
    logic                           w_en;
    t_stage                         w_src [0:DIV_STAGES];
    t_stage                         r_stage [0:DIV_STAGES-1];
    logic [HW_DIMS-1:0][PROD_W-1:0] r_prod;
    logic                           r_pv;
    logic [IDX_W-1:0]               r_out;
    logic                           r_ov;
    logic [IDX_W-1:0]               n_out;

    assign w_en    = !(r_ov && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_ov;
    assign o_flat_index = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < HW_DIMS; d++) begin
                r_text[d] <= EXT_W'(1);
                r_bext[d] <= EXT_W'(1);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx < REG_BLOCK_EXTENT_0) begin
                r_text[2'(i_cfg_idx - REG_TENSOR_EXTENT_0)] <= i_cfg_data;
            end else begin
                r_bext[2'(i_cfg_idx - REG_BLOCK_EXTENT_0)] <= i_cfg_data;
            end
        end
    end

    always_comb begin
        for (int d = 0; d < HW_DIMS; d++) begin
            w_bdiv[d] = eff_extent(r_bext[d]);
        end
    end

    // Tensor strides follow the configuration one multiply per cycle.
    always_ff @(posedge i_clk) begin
        r_ts[0] <= TS_W'(1);
        for (int d = 1; d < HW_DIMS; d++) begin
            r_ts[d] <= TS_W'(r_ts[d-1] * eff_extent(r_text[d-1]));
        end
    end

    always_comb begin
        w_src[0]          = '0;
        w_src[0].valid    = i_valid;
        w_src[0].num      = i_block_offset;
        w_src[0].start[0] = i_start_0;
        w_src[0].start[1] = i_start_1;
        w_src[0].start[2] = i_start_2;
        w_src[0].start[3] = i_start_3;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        localparam int Dim = k / OFS_W;
        localparam int Bit = k % OFS_W;
        t_stage             n_stage;
        logic [REM_W:0]     w_rem2;
        logic               w_ge;

        if (Bit == 0 && Dim > 0) begin : g_first
            always_comb begin
                n_stage            = w_src[k];
                n_stage.coord[Dim-1] = w_src[k].rem;
                n_stage.rem        = '0;
                w_rem2             = {n_stage.rem, n_stage.num[OFS_W-1]};
                w_ge               = w_rem2 >= w_bdiv[Dim];
                n_stage.num        = {n_stage.num[OFS_W-2:0], w_ge};
                n_stage.rem        = w_ge ? REM_W'(w_rem2 - w_bdiv[Dim]) : w_rem2[REM_W-1:0];
            end
        end else begin : g_step
            always_comb begin
                n_stage     = w_src[k];
                w_rem2      = {n_stage.rem, n_stage.num[OFS_W-1]};
                w_ge        = w_rem2 >= w_bdiv[Dim];
                n_stage.num = {n_stage.num[OFS_W-2:0], w_ge};
                n_stage.rem = w_ge ? REM_W'(w_rem2 - w_bdiv[Dim]) : w_rem2[REM_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stage[k].valid <= 1'b0;
            end else if (w_en) begin
                r_stage[k] <= n_stage;
            end
        end

        assign w_src[k+1] = r_stage[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_en) begin
            r_pv <= w_src[DIV_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int d = 0; d < HW_DIMS; d++) begin
                if (d >= DIMS) begin
                    r_prod[d] <= '0;
                end else if (d == DIMS - 1) begin
                    r_prod[d] <= PROD_W'(9'(w_src[DIV_STAGES].start[d])
                                 + 9'(w_src[DIV_STAGES].rem)) * PROD_W'(r_ts[d]);
                end else begin
                    r_prod[d] <= PROD_W'(9'(w_src[DIV_STAGES].start[d])
                                 + 9'(w_src[DIV_STAGES].coord[d])) * PROD_W'(r_ts[d]);
                end
            end
        end
    end

    always_comb begin
        n_out = '0;
        for (int d = 0; d < HW_DIMS; d++) begin
            n_out = n_out + r_prod[d][IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== design/tbag_checker.sv =====
`default_nettype none
`include "tensor_block_address_gen_top_assert.svh"
module tbag_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 o_stall,
    input  wire logic                                 o_valid,
    input  wire logic                                 i_stall,
    input  wire logic [tbag_pkg::IDX_W-1:0]           o_flat_index
);

    // A stalled result keeps its value.
    `TBAG_ASSERT_RUN(a_out_hold, o_valid && i_stall, ##1 (o_valid && $stable(o_flat_index)))
    // The input side is held back only by a waiting, stalled result.
    `TBAG_ASSERT_RUN(a_stall_cause, o_stall, o_valid && i_stall)
    // Reset empties the pipeline.
    `TBAG_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_valid && !o_stall)

endmodule

bind tensor_block_address_gen_top tbag_checker u_tbag_checker (.*);
`default_nettype wire
